>>> design/msfr_pkg.sv
`timescale 1ns / 1ps
// Package for the Modbus sensor frame receiver: frame constants, event and
// command codes, hunt states and the Modbus CRC-16 byte update. No dependencies.
package msfr_pkg;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned STORE_DEPTH = 10;

    localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT     = 1'd1;

    localparam logic       ENABLE_RESET     = 1'b1;
    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd100;

    localparam logic [7:0] MAX_ADDR   = 8'h04;
    localparam logic [7:0] MIN_ADDR   = 8'h01;
    localparam logic [7:0] FUNC_CODE  = 8'h03;
    localparam logic [7:0] COUNT_CODE = 8'h06;

    localparam logic [3:0] HDR_LEN   = 4'd3;
    localparam logic [3:0] CRC_LEN   = 4'd9;
    localparam logic [3:0] CRC_LO    = 4'd9;
    localparam logic [3:0] LAST_POS  = 4'd10;
    localparam logic [3:0] FRAME_LEN = 4'd11;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_EMPTY = 1'b1;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_ACCEPT = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;
    localparam logic [1:0] EV_IDLE   = 2'd3;

    typedef enum logic [1:0] {
        ST_ADDR  = 2'd0,
        ST_FUNC  = 2'd1,
        ST_COUNT = 2'd2,
        ST_BODY  = 2'd3
    } hunt_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> design/msfr_item_if.sv
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with command and received byte.
// Depends on nothing.
interface msfr_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

>>> design/msfr_result_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with event code and sensor fields.
// Depends on nothing.
interface msfr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [1:0] sensor_index;
    logic [7:0] segment;
    logic [7:0] deviation_left;
    logic [7:0] deviation_mid;
    logic [7:0] deviation_right;
    logic [7:0] point_low;
    logic [7:0] point_high;

    modport source (output valid, output event_res, output sensor_index, output segment,
                    output deviation_left, output deviation_mid, output deviation_right,
                    output point_low, output point_high, input ready);
    modport sink (input valid, input event_res, input sensor_index, input segment,
                  input deviation_left, input deviation_mid, input deviation_right,
                  input point_low, input point_high, output ready);
endinterface

>>> design/msfr_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on msfr_pkg for the field widths.
interface msfr_cfg_if;
    import msfr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/modbus_sensor_frame_receiver_unit.sv
// Modbus sensor frame receiver: hunts 11-byte RTU responses, checks the CRC-16
// and emits one result per item. Depends on msfr_pkg and the channel interfaces.
// The result is registered: result valid rises in the cycle after the item transfer.
// Throughput: one item per cycle while the result register is empty or being taken;
// the CRC byte update and frame check are combinational before the result register.
// Reset: rst_n asynchronous, active low; hunt restarts, CRC at 0xFFFF, enable 1, limit 100.
`timescale 1ns / 1ps
module modbus_sensor_frame_receiver_unit (
    input  logic           clk,
    input  logic           rst_n,
    msfr_item_if.sink      item,
    msfr_result_if.source  result,
    msfr_cfg_if.sink       cfg
);
    import msfr_pkg::*;

    logic        enable_reg;
    logic [7:0]  idle_limit_reg;

    hunt_t       hunt_reg;
    hunt_t       hunt_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  idle_reg;
    logic [7:0]  idle_next;
    logic [7:0]  frame_reg [STORE_DEPTH];

    logic        res_valid_reg;
    logic [1:0]  ev_reg;
    logic [1:0]  index_reg;
    logic [7:0]  seg_reg;
    logic [7:0]  off_l_reg;
    logic [7:0]  off_m_reg;
    logic [7:0]  off_r_reg;
    logic [7:0]  pt_l_reg;
    logic [7:0]  pt_h_reg;

    logic        accept;
    logic        fr_we;
    logic [3:0]  fr_idx;
    logic [15:0] crc_seed;
    logic [15:0] crc_upd;
    logic [7:0]  idle_inc;
    logic        frame_ok;
    logic [1:0]  ev_next;

    assign cfg.ready  = 1'b1;
    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign result.valid           = res_valid_reg;
    assign result.event_res       = ev_reg;
    assign result.sensor_index    = index_reg;
    assign result.segment         = seg_reg;
    assign result.deviation_left  = off_l_reg;
    assign result.deviation_mid   = off_m_reg;
    assign result.deviation_right = off_r_reg;
    assign result.point_low       = pt_l_reg;
    assign result.point_high      = pt_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= ENABLE_RESET;
            idle_limit_reg <= IDLE_LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_RECEIVE_ENABLE: enable_reg     <= cfg.data[0];
                REG_IDLE_LIMIT:     idle_limit_reg <= cfg.data[7:0];
                default:            ;
            endcase
        end
    end

    assign crc_seed = (hunt_reg == ST_ADDR) ? CRC_INIT : crc_reg;
    assign crc_upd  = crc16_byte(crc_seed, item.data_byte);
    assign idle_inc = idle_reg + 8'd1;
    assign frame_ok = (frame_reg[0] >= MIN_ADDR) && (frame_reg[0] <= MAX_ADDR)
                      && (frame_reg[CRC_LO] == crc_reg[7:0])
                      && (item.data_byte == crc_reg[15:8]);

    always_comb
    begin
        hunt_next  = hunt_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        idle_next  = idle_reg;
        fr_we      = 1'b0;
        fr_idx     = 4'd0;
        ev_next    = EV_NONE;
        if (accept && enable_reg)
        begin
            if (item.command == CMD_EMPTY)
            begin
                if (idle_inc >= idle_limit_reg)
                begin
                    idle_next  = 8'd0;
                    hunt_next  = ST_ADDR;
                    count_next = 4'd0;
                    ev_next    = EV_IDLE;
                end
                else
                begin
                    idle_next = idle_inc;
                end
            end
            else
            begin
                idle_next = 8'd0;
                case (hunt_reg)
                    ST_ADDR:
                    begin
                        if (item.data_byte <= MAX_ADDR)
                        begin
                            fr_we      = 1'b1;
                            fr_idx     = 4'd0;
                            crc_next   = crc_upd;
                            count_next = 4'd1;
                            hunt_next  = ST_FUNC;
                        end
                    end
                    ST_FUNC:
                    begin
                        if (item.data_byte == FUNC_CODE)
                        begin
                            fr_we      = 1'b1;
                            fr_idx     = 4'd1;
                            crc_next   = crc_upd;
                            count_next = 4'd2;
                            hunt_next  = ST_COUNT;
                        end
                        else
                        begin
                            hunt_next = ST_ADDR;
                        end
                    end
                    ST_COUNT:
                    begin
                        if (item.data_byte == COUNT_CODE)
                        begin
                            fr_we      = 1'b1;
                            fr_idx     = 4'd2;
                            crc_next   = crc_upd;
                            count_next = HDR_LEN;
                            hunt_next  = ST_BODY;
                        end
                        else
                        begin
                            hunt_next = ST_ADDR;
                        end
                    end
                    ST_BODY:
                    begin
                        if (count_reg < HDR_LEN || count_reg >= FRAME_LEN)
                        begin
                            hunt_next  = ST_ADDR;
                            count_next = 4'd0;
                        end
                        else
                        begin
                            if (count_reg < CRC_LEN)
                                crc_next = crc_upd;
                            if (count_reg < LAST_POS)
                            begin
                                fr_we      = 1'b1;
                                fr_idx     = count_reg;
                                count_next = count_reg + 4'd1;
                            end
                            else
                            begin
                                hunt_next  = ST_ADDR;
                                count_next = 4'd0;
                                ev_next    = frame_ok ? EV_ACCEPT : EV_REJECT;
                            end
                        end
                    end
                    default:
                    begin
                        hunt_next  = ST_ADDR;
                        count_next = 4'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg      <= ST_ADDR;
            count_reg     <= 4'd0;
            crc_reg       <= CRC_INIT;
            idle_reg      <= 8'd0;
            res_valid_reg <= 1'b0;
            ev_reg        <= EV_NONE;
        end
        else
        begin
            hunt_reg  <= hunt_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            idle_reg  <= idle_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
                ev_reg        <= ev_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
            frame_reg[fr_idx] <= item.data_byte;
    end

    // Hold sensor fields at zero unless the frame passes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (ev_next == EV_ACCEPT)
            begin
                index_reg <= 2'(frame_reg[0] - MIN_ADDR);
                seg_reg   <= frame_reg[3];
                off_l_reg <= frame_reg[4];
                off_m_reg <= frame_reg[5];
                off_r_reg <= frame_reg[6];
                pt_l_reg  <= frame_reg[7];
                pt_h_reg  <= frame_reg[8];
            end
            else
            begin
                index_reg <= 2'd0;
                seg_reg   <= 8'd0;
                off_l_reg <= 8'd0;
                off_m_reg <= 8'd0;
                off_r_reg <= 8'd0;
                pt_l_reg  <= 8'd0;
                pt_h_reg  <= 8'd0;
            end
        end
    end

`ifndef SYNTHESIS
    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("no result after item transfer");

    a_body_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        hunt_reg == ST_BODY |-> (count_reg >= HDR_LEN && count_reg <= LAST_POS))
        else $error("byte count out of range while collecting body");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && ev_reg != EV_ACCEPT) |->
            (index_reg == 2'd0 && seg_reg == 8'd0 && off_l_reg == 8'd0
             && off_m_reg == 8'd0 && off_r_reg == 8'd0 && pt_l_reg == 8'd0
             && pt_h_reg == 8'd0))
        else $error("sensor fields nonzero without accepted frame");

    a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg) |=> (ev_reg == EV_NONE && $stable(hunt_reg)))
        else $error("state or event changed while receive disabled");
`endif

endmodule

>>> verif/modbus_sensor_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for modbus_sensor_frame_receiver_unit: drives received bytes and empty
// polls, predicts the event and sensor fields of every result and checks them.
// Depends on msfr_pkg and the item, result and configuration interfaces.
module modbus_sensor_frame_receiver_unit_tb;
    import msfr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [1:0] ev;
        logic [1:0] idx;
        logic [7:0] seg;
        logic [7:0] off_l;
        logic [7:0] off_m;
        logic [7:0] off_r;
        logic [7:0] pt_lo;
        logic [7:0] pt_hi;
    } sensor_report_t;

    class frame_tracker;
        logic           enable;
        logic [7:0]     limit;
        hunt_t          step;
        logic [3:0]     count;
        logic [15:0]    crc;
        logic [7:0]     frame [STORE_DEPTH];
        logic [7:0]     idle;
        sensor_report_t pending [$];
        int             mismatches;
        int             items;
        int             accepted;
        int             rejected;
        int             idle_resets;
        int             ignored;

        function new();
            enable      = ENABLE_RESET;
            limit       = IDLE_LIMIT_RESET;
            step        = ST_ADDR;
            count       = '0;
            crc         = CRC_INIT;
            idle        = '0;
            foreach (frame[k])
                frame[k] = '0;
            mismatches  = 0;
            items       = 0;
            accepted    = 0;
            rejected    = 0;
            idle_resets = 0;
            ignored     = 0;
        endfunction

        static function logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] octet);
            logic [15:0] r;
            logic        fb;
            r = acc;
            for (int k = 0; k < 8; k++)
            begin
                fb = r[0] ^ octet[k];
                r  = r >> 1;
                if (fb)
                    r = r ^ CRC_POLY;
            end
            return r;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            if (idx == REG_RECEIVE_ENABLE)
                enable = val[0];
            else if (idx == REG_IDLE_LIMIT)
                limit = val;
        endfunction

        function void absorb_item(input logic cmd, input logic [7:0] octet);
            sensor_report_t rep;
            logic [3:0]     pos;
            bit             ok;
            rep = '0;
            items++;
            if (!enable)
                ignored++;
            else if (cmd == CMD_EMPTY)
            begin
                idle++;
                if (idle >= limit)
                begin
                    idle   = '0;
                    step   = ST_ADDR;
                    count  = '0;
                    rep.ev = EV_IDLE;
                    idle_resets++;
                end
            end
            else
            begin
                idle = '0;
                case (step)
                    ST_ADDR:
                    begin
                        if (octet <= MAX_ADDR)
                        begin
                            frame[0] = octet;
                            crc      = crc_step(CRC_INIT, octet);
                            count    = 4'd1;
                            step     = ST_FUNC;
                        end
                    end
                    ST_FUNC:
                    begin
                        if (octet == FUNC_CODE)
                        begin
                            frame[1] = octet;
                            crc      = crc_step(crc, octet);
                            count    = 4'd2;
                            step     = ST_COUNT;
                        end
                        else
                            step = ST_ADDR;
                    end
                    ST_COUNT:
                    begin
                        if (octet == COUNT_CODE)
                        begin
                            frame[2] = octet;
                            crc      = crc_step(crc, octet);
                            count    = HDR_LEN;
                            step     = ST_BODY;
                        end
                        else
                            step = ST_ADDR;
                    end
                    default:
                    begin
                        pos = count;
                        if (pos < CRC_LEN)
                            crc = crc_step(crc, octet);
                        if (pos < LAST_POS)
                        begin
                            frame[pos] = octet;
                            count      = pos + 4'd1;
                        end
                        else
                        begin
                            ok = frame[0] >= MIN_ADDR && frame[0] <= MAX_ADDR &&
                                 frame[CRC_LO] == crc[7:0] && octet == crc[15:8];
                            step  = ST_ADDR;
                            count = '0;
                            if (ok)
                            begin
                                rep.ev    = EV_ACCEPT;
                                rep.idx   = frame[0][1:0] - 2'd1;
                                rep.seg   = frame[3];
                                rep.off_l = frame[4];
                                rep.off_m = frame[5];
                                rep.off_r = frame[6];
                                rep.pt_lo = frame[7];
                                rep.pt_hi = frame[8];
                                accepted++;
                            end
                            else
                            begin
                                rep.ev = EV_REJECT;
                                rejected++;
                            end
                        end
                    end
                endcase
            end
            pending.push_back(rep);
        endfunction

        function void check_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                             $time, name, want, got);
            end
        endfunction

        function void match_report(input sensor_report_t got);
            sensor_report_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none pending, expected nothing, actual event %0d",
                             $time, got.ev);
                return;
            end
            want = pending.pop_front();
            check_field("event_res", want.ev, got.ev);
            check_field("sensor_index", want.idx, got.idx);
            check_field("segment", want.seg, got.seg);
            check_field("deviation_left", want.off_l, got.off_l);
            check_field("deviation_mid", want.off_m, got.off_m);
            check_field("deviation_right", want.off_r, got.off_r);
            check_field("point_low", want.pt_lo, got.pt_lo);
            check_field("point_high", want.pt_hi, got.pt_hi);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    msfr_item_if   item_ch ();
    msfr_result_if res_ch ();
    msfr_cfg_if    cfg_ch ();

    modbus_sensor_frame_receiver_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    frame_tracker tracker;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_len       = 0;
    int           sent_count     = 0;
    logic [7:0]   cur_limit      = IDLE_LIMIT_RESET;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : result_sink
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                res_ch.ready = 1'b0;
                hold_len--;
            end
            else
                res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : result_monitor
        sensor_report_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.ev    = res_ch.event_res;
                got.idx   = res_ch.sensor_index;
                got.seg   = res_ch.segment;
                got.off_l = res_ch.deviation_left;
                got.off_m = res_ch.deviation_mid;
                got.off_r = res_ch.deviation_right;
                got.pt_lo = res_ch.point_low;
                got.pt_hi = res_ch.point_high;
                tracker.match_report(got);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid & item_ch.ready) === 1'b1 ||
                (res_ch.valid & res_ch.ready) === 1'b1 ||
                (cfg_ch.valid & cfg_ch.ready) === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, tracker.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_item(input logic cmd, input logic [7:0] octet);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.command   = cmd;
        item_ch.data_byte = octet;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.absorb_item(cmd, octet);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        tracker.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic configure(input logic en, input logic [7:0] lim);
        cfg_write(REG_RECEIVE_ENABLE, {7'd0, en});
        cfg_write(REG_IDLE_LIMIT, lim);
        cfg_ch.valid = 1'b0;
        cur_limit    = lim;
    endtask

    task automatic drain();
        item_ch.valid = 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [47:0] body,
                              input bit corrupt, input int poll_at);
        logic [7:0]  bytes [FRAME_LEN];
        logic [15:0] acc;
        int          p;
        int          b;
        bytes[0] = addr;
        bytes[1] = FUNC_CODE;
        bytes[2] = COUNT_CODE;
        for (int k = 0; k < 6; k++)
            bytes[3 + k] = body[8 * k +: 8];
        acc = CRC_INIT;
        for (int k = 0; k < CRC_LEN; k++)
            acc = frame_tracker::crc_step(acc, bytes[k]);
        bytes[9]  = acc[7:0];
        bytes[10] = acc[15:8];
        if (corrupt)
        begin
            p = $urandom_range(10, 3);
            b = $urandom_range(7);
            bytes[p][b] = ~bytes[p][b];
        end
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            if (k == poll_at)
                repeat ($urandom_range(1, 3)) push_item(CMD_EMPTY, 8'($urandom_range(255)));
            push_item(CMD_BYTE, bytes[k]);
        end
    endtask

    task automatic random_traffic(input int n_items);
        int         start;
        int         pick;
        int         len;
        logic [7:0] val;
        start = sent_count;
        while (sent_count - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                val = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
                send_frame(val, 48'({$urandom, $urandom}), $urandom_range(9) == 0,
                           ($urandom_range(6) == 0) ? $urandom_range(1, 10) : -1);
            end
            else if (pick < 70)
            begin
                push_item(CMD_BYTE, 8'($urandom_range(4)));
                if ($urandom_range(1) == 0)
                begin
                    push_item(CMD_BYTE, FUNC_CODE);
                    do val = 8'($urandom_range(255)); while (val == COUNT_CODE);
                end
                else
                    do val = 8'($urandom_range(255)); while (val == FUNC_CODE);
                push_item(CMD_BYTE, val);
            end
            else if (pick < 85)
            begin
                len = ($urandom_range(1) == 0) ? $urandom_range(1, 4)
                                               : $urandom_range(1, int'(cur_limit) + 1);
                repeat (len) push_item(CMD_EMPTY, 8'($urandom_range(255)));
            end
            else
                repeat ($urandom_range(1, 4)) push_item(CMD_BYTE, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input logic en, input logic [7:0] lim, input int sidle,
                             input int rstall, input int hold, input int n_items);
        configure(en, lim);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        hold_len       = hold;
        random_traffic(n_items);
        drain();
    endtask

    initial
    begin
        tracker           = new();
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.command   = CMD_BYTE;
        item_ch.data_byte = 8'd0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_RECEIVE_ENABLE;
        cfg_ch.data       = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        configure(1'b1, 8'd2);
        send_frame(MAX_ADDR, 48'h01_80_5A_A5_00_FF, 1'b0, -1);
        push_item(CMD_BYTE, 8'hFF);
        push_item(CMD_BYTE, 8'h05);
        push_item(CMD_BYTE, 8'h01);
        push_item(CMD_BYTE, 8'h02);
        push_item(CMD_BYTE, 8'h05);
        push_item(CMD_BYTE, 8'h02);
        push_item(CMD_BYTE, FUNC_CODE);
        push_item(CMD_BYTE, 8'h07);
        push_item(CMD_BYTE, 8'h03);
        push_item(CMD_BYTE, FUNC_CODE);
        push_item(CMD_EMPTY, 8'h00);
        push_item(CMD_EMPTY, 8'hFF);
        push_item(CMD_BYTE, COUNT_CODE);
        drain();

        run_phase(1'b1, 8'd100, 0, 0, 0, 230);
        run_phase(1'b1, 8'd1, 48, 0, 0, 230);
        run_phase(1'b0, 8'd1, 0, 48, 0, 60);
        run_phase(1'b1, 8'd255, 11, 11, 0, 230);
        run_phase(1'b1, 8'd0, 0, 0, 150, 230);
        run_phase(1'b1, 8'd7, 48, 0, 0, 230);
        run_phase(1'b1, 8'd3, 0, 48, 0, 230);
        run_phase(1'b1, 8'd20, 11, 11, 0, 230);

        repeat (4) @(posedge clk);
        $display("Run covered %0d items: %0d frames accepted, %0d rejected, %0d idle resets,",
                 tracker.items, tracker.accepted, tracker.rejected, tracker.idle_resets);
        $display("%0d ignored with receive off; idle limits 0 to 255, long result hold-off.",
                 tracker.ignored);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
